// ----- rtl/rfdc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfdc_pkg: shared types and functions for the radio frame descrambler
// Holds status codes, register indexes, the result record and the
// unrolled LFSR and CRC-16-CCITT step functions.
// ----------------------------------------------------------------------------
package rfdc_pkg;

    localparam int unsigned CfgIdxW = 2;

    localparam logic [7:0]  RstManufacturer = 8'd4;
    localparam logic [7:0]  RstProduct      = 8'd3;
    localparam logic [7:0]  RstSeedId       = 8'd242;

    localparam logic [15:0] LfsrTaps    = 16'hf5f5;
    localparam logic [7:0]  DescrMask   = 8'h5a;
    localparam logic [15:0] CrcPoly     = 16'h1021;
    localparam int unsigned LfsrShifts  = 5;
    localparam logic [7:0]  FirstPayPos = 8'd4;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_MANUF = 3'd2,
        ST_PROD  = 3'd3,
        ST_CRC   = 3'd4
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MANUFACTURER = 2'd0,
        CFG_PRODUCT      = 2'd1,
        CFG_SEED_ID      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       frame_last;
        t_status    frame_status;
    } t_result;

    typedef struct packed {
        logic [7:0] manufacturer;
        logic [7:0] product;
        logic [7:0] seed_id;
    } t_cfg;

    // five right shifts, folding in the taps when a one drops out
    function automatic logic [15:0] lfsr_advance(input logic [15:0] s_in);
        logic [15:0] s;
        s = s_in;
        for (int k = 0; k < LfsrShifts; k++) begin
            if (s[0]) begin
                s = (s >> 1) ^ LfsrTaps;
            end else begin
                s = s >> 1;
            end
        end
        return s;
    endfunction

    // one byte of CRC-16-CCITT, MSB first
    function automatic logic [15:0] crc_update(input logic [15:0] r_in,
                                               input logic [7:0]  b);
        logic [15:0] r;
        r = r_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CrcPoly;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rfdc_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfdc_in_if: receive byte channel
// Valid/ready channel carrying one received byte and its frame start flag.
// ----------------------------------------------------------------------------
interface rfdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface
`default_nettype wire

// ----- rtl/rfdc_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfdc_out_if: result channel
// Valid/ready channel carrying one result word per frame byte.
// ----------------------------------------------------------------------------
interface rfdc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       frame_last;
    logic [2:0] frame_status;

    modport source (output valid, output data_byte, output byte_index,
                    output frame_last, output frame_status, input ready);
    modport sink   (input valid, input data_byte, input byte_index,
                    input frame_last, input frame_status, output ready);
endinterface
`default_nettype wire

// ----- rtl/radio_frame_descramble_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// radio_frame_descramble_check: frame descrambler with header and CRC check
// Tracks frames byte by byte, passes the header raw, descrambles the payload
// with a seeded LFSR and checks CRC-16-CCITT, reporting status on last byte.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  i_rx    | in  | valid/ready   | rx_byte[7:0], frame_start
//  o_res   | out | valid/ready   | data_byte, byte_index, frame_last, frame_status
//  i_cfg_* | in  | write enable  | i_cfg_idx[1:0], i_cfg_data[7:0]
//
//  One byte per cycle while the output register is free; a result appears in the
//  cycle after its byte is taken, held in the single output register behind the LFSR/CRC logic.
//  Input ready is high while the output register is empty or being drained.
//  Bytes that make no result are taken at full rate as well, under the same ready.
//  Reset is synchronous; config registers return to their default values.
// ----------------------------------------------------------------------------
module radio_frame_descramble_check (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rfdc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [7:0]                    i_cfg_data,
    rfdc_in_if.sink                            i_rx,
    rfdc_out_if.source                         o_res
);
    import rfdc_pkg::*;

    t_cfg    r_cfg;
    logic    accept;
    logic    core_valid;
    t_result core_res;
    logic    slot_free;
    logic    res_valid;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{manufacturer: RstManufacturer, product: RstProduct,
                       seed_id: RstSeedId};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MANUFACTURER: r_cfg.manufacturer <= i_cfg_data;
                CFG_PRODUCT:      r_cfg.product      <= i_cfg_data;
                CFG_SEED_ID:      r_cfg.seed_id      <= i_cfg_data;
                default: ;  // unmapped index: drop
            endcase
        end
    end

    assign i_rx.ready = slot_free;
    assign accept     = i_rx.valid && slot_free;

    rfdc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx.rx_byte),
        .i_frame_start (i_rx.frame_start),
        .i_cfg         (r_cfg),
        .o_res_valid   (core_valid),
        .o_res         (core_res)
    );

    rfdc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (core_valid),
        .i_res   (core_res),
        .i_ready (o_res.ready),
        .o_free  (slot_free),
        .o_valid (res_valid),
        .o_res   (res)
    );

    assign o_res.valid        = res_valid;
    assign o_res.data_byte    = res.data_byte;
    assign o_res.byte_index   = res.byte_index;
    assign o_res.frame_last   = res.frame_last;
    assign o_res.frame_status = res.frame_status;

endmodule
`default_nettype wire

// ----- rtl/rfdc_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfdc_core: frame tracker, descrambler and CRC checker
// Holds the per-frame state and works out the result for each accepted byte.
// ----------------------------------------------------------------------------
module rfdc_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic             i_frame_start,
    input  wire rfdc_pkg::t_cfg   i_cfg,
    output logic                  o_res_valid,
    output rfdc_pkg::t_result     o_res
);
    import rfdc_pkg::*;

    logic [7:0]  r_pos,   n_pos;
    logic [7:0]  r_len,   n_len;
    logic [7:0]  r_seedh, n_seedh;
    logic [15:0] r_lfsr,  n_lfsr;
    logic [15:0] r_crc,   n_crc;
    t_status     r_herr,  n_herr;

    logic [15:0] lfsr_adv;
    logic [7:0]  descr;
    logic [7:0]  pos_inc;
    logic        in_frame;
    logic        last;

    assign lfsr_adv = lfsr_advance(r_lfsr);
    assign descr    = lfsr_adv[7:0] ^ i_rx_byte ^ DescrMask;
    assign pos_inc  = r_pos + 8'd1;
    assign in_frame = (r_pos < r_len);
    assign last     = (pos_inc == r_len);

    always_comb begin
        n_pos       = r_pos;
        n_len       = r_len;
        n_seedh     = r_seedh;
        n_lfsr      = r_lfsr;
        n_crc       = r_crc;
        n_herr      = r_herr;
        o_res_valid = 1'b0;
        o_res       = '{data_byte: i_rx_byte, byte_index: r_pos,
                        frame_last: 1'b0, frame_status: ST_OK};

        if (i_accept) begin
            if (i_frame_start) begin
                n_len  = i_rx_byte;
                n_pos  = '0;
                n_crc  = '0;
                n_herr = ST_OK;
                if (i_rx_byte == 8'd0) begin
                    o_res_valid = 1'b1;
                    o_res = '{data_byte: 8'd0, byte_index: 8'd0,
                              frame_last: 1'b1, frame_status: ST_SHORT};
                end
            end else if (in_frame) begin
                o_res_valid = 1'b1;
                n_pos       = pos_inc;
                unique case (r_pos)
                    8'd0: begin
                        if (i_rx_byte != i_cfg.manufacturer && r_herr == ST_OK)
                            n_herr = ST_MANUF;
                    end
                    8'd1: begin
                        if (i_rx_byte != i_cfg.product && r_herr == ST_OK)
                            n_herr = ST_PROD;
                    end
                    8'd2: begin
                        n_seedh = i_rx_byte;
                    end
                    8'd3: begin
                        n_lfsr = {i_cfg.seed_id ^ r_seedh, i_rx_byte};
                    end
                    default: begin
                        n_lfsr = lfsr_adv;
                        n_crc  = crc_update(r_crc, descr);
                        o_res.data_byte = descr;
                    end
                endcase

                if (last) begin
                    o_res.frame_last = 1'b1;
                    priority if (r_len < 8'd2)
                        o_res.frame_status = ST_SHORT;
                    else if (n_herr != ST_OK)
                        o_res.frame_status = n_herr;
                    else if (r_len < FirstPayPos)
                        o_res.frame_status = ST_SHORT;
                    else if (n_crc != 16'd0)
                        o_res.frame_status = ST_CRC;
                    else
                        o_res.frame_status = ST_OK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_seedh <= '0;
            r_lfsr  <= '0;
            r_crc   <= '0;
            r_herr  <= ST_OK;
        end else begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_seedh <= n_seedh;
            r_lfsr  <= n_lfsr;
            r_crc   <= n_crc;
            r_herr  <= n_herr;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rfdc_out_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfdc_out_reg: result output register
// Holds one result word and takes a new one whenever the slot frees up.
// ----------------------------------------------------------------------------
module rfdc_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire rfdc_pkg::t_result i_res,
    input  wire logic              i_ready,
    output logic                   o_free,
    output logic                   o_valid,
    output rfdc_pkg::t_result      o_res
);
    import rfdc_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // slot is free when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/radio_frame_descramble_check_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// radio_frame_descramble_check_tb: frame descrambler and checker testbench
// Sends directed and random radio frames (good, bad ids, bad CRC, cut short,
// stray bytes) under several id settings. A scoreboard predicts every result
// word and checks the output field by field. Each side stalls at random in some phases.
// ----------------------------------------------------------------------------
import rfdc_pkg::*;

class frame_byte_tracker;
    logic [7:0]  manufacturer;
    logic [7:0]  product;
    logic [7:0]  seed_id;
    logic [7:0]  position;
    logic [7:0]  length;
    logic [7:0]  seed_high;
    logic [15:0] lfsr;
    logic [15:0] crc;
    t_status     header_status;
    t_result     due_words[$];
    int unsigned failures;

    function new();
        manufacturer  = RstManufacturer;
        product       = RstProduct;
        seed_id       = RstSeedId;
        position      = '0;
        length        = '0;
        seed_high     = '0;
        lfsr          = '0;
        crc           = '0;
        header_status = ST_OK;
        failures      = 0;
    endfunction

    static function logic [15:0] lfsr_next(input logic [15:0] s_in);
        logic [15:0] s;
        s = s_in;
        repeat (LfsrShifts) s = s[0] ? ((s >> 1) ^ LfsrTaps) : (s >> 1);
        return s;
    endfunction

    static function logic [15:0] crc_next(input logic [15:0] r_in, input logic [7:0] b);
        logic [15:0] r;
        r = r_in ^ {b, 8'h00};
        repeat (8) r = {r[14:0], 1'b0} ^ (r[15] ? CrcPoly : 16'h0000);
        return r;
    endfunction

    function void take_rx_byte(input logic [7:0] b, input logic start);
        t_result    w;
        logic [7:0] pos;
        if (start) begin
            length        = b;
            position      = '0;
            crc           = '0;
            header_status = ST_OK;
            if (b == 8'd0) begin
                w.data_byte    = '0;
                w.byte_index   = '0;
                w.frame_last   = 1'b1;
                w.frame_status = ST_SHORT;
                due_words.push_back(w);
            end
            return;
        end
        // outside a frame: drop
        if (position >= length) return;
        pos = position;
        w.data_byte = b;
        case (pos)
            8'd0: if (b != manufacturer && header_status == ST_OK) header_status = ST_MANUF;
            8'd1: if (b != product && header_status == ST_OK) header_status = ST_PROD;
            8'd2: seed_high = b;
            8'd3: lfsr = {seed_id ^ seed_high, b};
            default: begin
                lfsr = lfsr_next(lfsr);
                w.data_byte = lfsr[7:0] ^ b ^ DescrMask;
                crc = crc_next(crc, w.data_byte);
            end
        endcase
        position       = pos + 8'd1;
        w.byte_index   = pos;
        w.frame_last   = (position == length);
        w.frame_status = ST_OK;
        if (w.frame_last) begin
            if (length < 8'd2) w.frame_status = ST_SHORT;
            else if (header_status != ST_OK) w.frame_status = header_status;
            else if (length < FirstPayPos) w.frame_status = ST_SHORT;
            else if (crc != 16'h0000) w.frame_status = ST_CRC;
        end
        due_words.push_back(w);
    endfunction

    function void check_word(input logic [7:0] data, input logic [7:0] idx,
                             input logic last, input logic [2:0] status);
        t_result w;
        if (due_words.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: unexpected word: data %02h index %0d last %0b status %0d",
                         $time, data, idx, last, status);
            return;
        end
        w = due_words.pop_front();
        if (w.data_byte !== data || w.byte_index !== idx || w.frame_last !== last ||
            w.frame_status !== status) begin
            failures++;
            if (failures <= 10)
                $display("%0t: word mismatch: expected %02h/%0d/%0b/%0d got %02h/%0d/%0b/%0d",
                         $time, w.data_byte, w.byte_index, w.frame_last, w.frame_status,
                         data, idx, last, status);
        end
    endfunction
endclass

module radio_frame_descramble_check_tb;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [7:0]  cfg_data;
    logic        res_ready = 1'b0;
    int unsigned stall_left = 0;
    int unsigned res_stall_pct = 0;
    int unsigned rx_gap_pct = 0;
    int unsigned frame_bytes = 0;

    frame_byte_tracker tracker = new();

    rfdc_in_if  rx_if ();
    rfdc_out_if res_if ();

    assign res_if.ready = res_ready;

    radio_frame_descramble_check dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_if),
        .o_res      (res_if)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // result side back-pressure in short bursts
    always @(negedge clk) begin
        if (res_stall_pct == 0) begin
            res_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < res_stall_pct) begin
            res_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            res_ready  <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (res_if.valid && res_if.ready)
                tracker.check_word(res_if.data_byte, res_if.byte_index,
                                   res_if.frame_last, res_if.frame_status);
            if (rx_if.valid && rx_if.ready)
                tracker.take_rx_byte(rx_if.rx_byte, rx_if.frame_start);
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_byte(input logic [7:0] b, input logic start);
        int unsigned gap;
        if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
            gap = $urandom_range(1, 5);
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_if.valid       <= 1'b1;
        rx_if.rx_byte     <= b;
        rx_if.frame_start <= start;
        do @(posedge clk); while (!rx_if.ready);
        @(negedge clk);
    endtask

    // scramble a frame the way a transmitter would; keep < len cuts it short
    task automatic send_frame(input int unsigned len, input logic [7:0] manuf,
                              input logic [7:0] prod, input logic [15:0] seed,
                              input bit bad_crc, input int unsigned keep);
        logic [15:0] scr;
        logic [15:0] sum;
        logic [7:0]  plain;
        logic [7:0]  raw;
        int unsigned n;
        n   = (keep < len) ? keep : len;
        scr = '0;
        sum = '0;
        send_byte(8'(len), 1'b1);
        for (int unsigned i = 0; i < n; i++) begin
            case (i)
                0: raw = manuf;
                1: raw = prod;
                2: raw = seed[15:8];
                3: begin
                    raw = seed[7:0];
                    scr = {tracker.seed_id ^ seed[15:8], seed[7:0]};
                end
                default: begin
                    if (len >= 6 && i == len - 2) begin
                        plain = sum[15:8];
                    end else if (len >= 6 && i == len - 1) begin
                        plain = sum[7:0];
                    end else begin
                        plain = 8'($urandom_range(0, 255));
                        sum   = crc_update(sum, plain);
                    end
                    scr = lfsr_advance(scr);
                    raw = plain ^ scr[7:0] ^ DescrMask;
                    if (bad_crc && i == len - 1) raw = raw ^ 8'($urandom_range(1, 255));
                end
            endcase
            send_byte(raw, 1'b0);
        end
        frame_bytes += n + 1;
    endtask

    task automatic run_frames(input int unsigned quota);
        int unsigned stop_at;
        int unsigned len;
        int unsigned keep;
        logic [7:0]  m;
        logic [7:0]  p;
        stop_at = frame_bytes + quota;
        while (frame_bytes < stop_at) begin
            len = ($urandom_range(0, 99) < 12) ? $urandom_range(0, 5) : $urandom_range(6, 24);
            m = tracker.manufacturer;
            p = tracker.product;
            if ($urandom_range(0, 19) == 0) m = m ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 19) == 0) p = p ^ 8'($urandom_range(1, 255));
            keep = (len != 0 && $urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : len;
            send_frame(len, m, p, 16'($urandom), $urandom_range(0, 6) == 0, keep);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        end
    endtask

    // hold input idle until every predicted word is out, then let the pipe settle
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        while (tracker.due_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_ids(input logic [7:0] m, input logic [7:0] p, input logic [7:0] s);
        tracker.manufacturer = m;
        tracker.product      = p;
        tracker.seed_id      = s;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MANUFACTURER;
        cfg_data <= m;
        @(negedge clk);
        cfg_idx  <= CFG_PRODUCT;
        cfg_data <= p;
        @(negedge clk);
        cfg_idx  <= CFG_SEED_ID;
        cfg_data <= s;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_MANUFACTURER;
        cfg_data          = '0;
        rx_if.valid       = 1'b0;
        rx_if.rx_byte     = '0;
        rx_if.frame_start = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        rx_gap_pct    = 20;
        res_stall_pct = 20;
        // stray byte before any frame, then the short and header-error cases
        send_byte(8'hff, 1'b0);
        send_frame(0, 8'h00, 8'h00, 16'h0000, 1'b0, 0);
        send_frame(1, 8'hff, 8'h00, 16'h0000, 1'b0, 1);
        send_frame(2, 8'h00, 8'hff, 16'h0000, 1'b0, 2);
        send_frame(3, tracker.manufacturer, 8'h00, 16'h0000, 1'b0, 3);
        send_frame(4, tracker.manufacturer, tracker.product, 16'hffff, 1'b0, 4);
        // abandon a frame with a new start
        send_frame(6, tracker.manufacturer, tracker.product, 16'h0000, 1'b0, 2);
        send_frame(6, tracker.manufacturer, tracker.product, 16'h1234, 1'b0, 6);
        send_byte(8'h00, 1'b0);
        run_frames(120);
        wait_idle();

        // change every id in the middle of an open frame
        send_byte(8'd6, 1'b1);
        send_byte(tracker.manufacturer, 1'b0);
        wait_idle();
        load_ids(8'h00, 8'h00, 8'h00);
        send_byte(8'h00, 1'b0);
        repeat (4) send_byte(8'($urandom), 1'b0);
        frame_bytes += 7;
        rx_gap_pct    = 0;
        res_stall_pct = 35;
        run_frames(120);
        wait_idle();

        load_ids(8'hff, 8'hff, 8'hff);
        rx_gap_pct    = 30;
        res_stall_pct = 10;
        send_frame(255, 8'hff, 8'hff, 16'($urandom), 1'b0, 255);
        run_frames(100);
        wait_idle();

        load_ids(8'($urandom), 8'($urandom), 8'($urandom));
        rx_gap_pct    = 40;
        res_stall_pct = 0;
        run_frames(120);
        wait_idle();

        // last stretch runs at full rate on both sides
        load_ids(8'($urandom), 8'($urandom), 8'($urandom));
        rx_gap_pct    = 0;
        res_stall_pct = 0;
        run_frames(120);
        wait_idle();

        if (tracker.failures == 0 && tracker.due_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// ----- radio_frame_descramble_check.f -----
rtl/rfdc_pkg.sv
rtl/rfdc_in_if.sv
rtl/rfdc_out_if.sv
rtl/rfdc_core.sv
rtl/rfdc_out_reg.sv
rtl/radio_frame_descramble_check.sv
tb/sv/radio_frame_descramble_check_tb.sv
